FILE: rtl/x86_alu_register_memory_executor_defines.svh
// Assertion macros for the x86 ALU register/memory executor.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef X86_ALU_REGISTER_MEMORY_EXECUTOR_DEFINES_SVH
`define X86_ALU_REGISTER_MEMORY_EXECUTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define X86E_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("x86 executor check failed");
`define X86E_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("x86 executor check failed");
`else
`define X86E_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define X86E_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/x86e_pkg.sv
// Shared types and constants for the x86 ALU register/memory executor.
// No dependencies.
`default_nettype none

package x86e_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam logic [15:0] SP_RESET = 16'hFFFE;
  localparam logic [REG_AW-1:0] SP_INDEX = REG_AW'(REG_COUNT - 1);

  typedef enum logic [2:0] {
    OP_MOV = 3'd0,
    OP_ADD = 3'd1,
    OP_AND = 3'd2,
    OP_OR  = 3'd3,
    OP_XOR = 3'd4,
    OP_SUB = 3'd5,
    OP_INC = 3'd6,
    OP_DEC = 3'd7
  } op_t;

  localparam logic [1:0] SRC_REG = 2'd0;
  localparam logic [1:0] SRC_MEM = 2'd1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_RD0   = 8'b00000100,
    ST_RD1   = 8'b00001000,
    ST_RD2   = 8'b00010000,
    ST_EX    = 8'b00100000,
    ST_WR1   = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_t;

  // first field in the highest bits, last field in the lowest bits
  typedef struct packed {
    logic [15:0] immediate;
    logic [15:0] address;
    logic [2:0]  src_reg;
    logic [2:0]  dest_reg;
    logic [1:0]  source_kind;
    logic        dest_is_memory;
    logic        word_size;
    logic [2:0]  mode;
  } item_t;

  typedef struct packed {
    logic        bad_operands;
    logic        borrow_flag;
    logic [15:0] result;
  } res_t;

  function automatic logic [15:0] sel_operand(input logic word, input logic hi,
                                              input logic [15:0] v);
    logic [15:0] o;
    if (word) begin
      o = v;
    end else if (hi) begin
      o = {8'h00, v[15:8]};
    end else begin
      o = {8'h00, v[7:0]};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/x86e_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module x86e_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/x86_alu_register_memory_executor.sv
// A transaction steps through RD0, RD1, RD2, EX, WR1 (word to memory only) and FIN;
// memory-to-memory goes from IDLE straight to FIN. A new one is accepted only in IDLE, so
// the read/modify/write sequence on the byte-wide data RAM sets the pace; stalls hold FIN.
// Reset: synchronous; a clearing pass over all MEM_BYTES addresses zeroes the data RAM and loads
// the register RAM (stack pointer 0xFFFE) before the first transaction is accepted.
// Depends on x86e_pkg, x86e_ram and the assertion macro header.
`default_nettype none
`include "x86_alu_register_memory_executor_defines.svh"

module x86_alu_register_memory_executor
  import x86e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // mode[2:0], word_size[3], dest_is_memory[4], source_kind[6:5], dest_reg[9:7],
  // src_reg[12:10], address[28:13], immediate[44:29], zero[47:45]
  input  wire logic [47:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result[15:0], borrow_flag[16], bad_operands[17], zero[23:18]
  output      logic [23:0] m_axis_tdata
);

  state_t            state;
  item_t             item;
  logic [MEM_AW-1:0] clr_cnt;
  logic              borrow;
  logic              bad;
  logic [15:0]       res;
  logic [15:0]       reg_d, reg_s;
  logic [7:0]        mem_lo, mem_hi;
  res_t              out_q;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              reg_we;
  logic [REG_AW-1:0] reg_waddr, reg_raddr;
  logic [15:0]       reg_wdata, reg_rdata;

  item_t             in_item;
  logic              in_fire;
  logic              out_free;
  logic [MEM_AW-1:0] a0, a1;
  logic [REG_AW-1:0] dphys, sphys;
  logic [15:0]       mask, d, s, r, reg_merge;
  logic              borrow_set;

  assign in_item       = item_t'(s_axis_tdata[44:0]);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {6'd0, out_q};

  assign a0    = item.address[MEM_AW-1:0];
  assign a1    = a0 + MEM_AW'(1);
  assign dphys = item.word_size ? item.dest_reg : {1'b0, item.dest_reg[2:1]};
  assign sphys = item.word_size ? item.src_reg : {1'b0, item.src_reg[2:1]};
  assign mask  = item.word_size ? 16'hFFFF : 16'h00FF;

  always_comb begin
    d = item.dest_is_memory ? sel_operand(item.word_size, 1'b0, {mem_hi, mem_lo})
                            : sel_operand(item.word_size, item.dest_reg[0], reg_d);
    case (item.source_kind)
      SRC_REG: s = sel_operand(item.word_size, item.src_reg[0], reg_s);
      SRC_MEM: s = sel_operand(item.word_size, 1'b0, {mem_hi, mem_lo});
      default: s = item.immediate & mask;
    endcase
    borrow_set = 1'b0;
    case (op_t'(item.mode))
      OP_MOV:  r = s;
      OP_ADD:  r = (d + s) & mask;
      OP_AND:  r = d & s;
      OP_OR:   r = d | s;
      OP_XOR:  r = d ^ s;
      OP_SUB: begin
        r = (d - s) & mask;
        borrow_set = (d < s);
      end
      OP_INC:  r = (d + 16'd1) & mask;
      default: begin
        r = (d - 16'd1) & mask;
        borrow_set = (d == 16'd0);
      end
    endcase
    if (item.word_size) begin
      reg_merge = r;
    end else if (item.dest_reg[0]) begin
      reg_merge = {r[7:0], reg_d[7:0]};
    end else begin
      reg_merge = {reg_d[15:8], r[7:0]};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a0;
    mem_wdata = r[7:0];
    mem_raddr = (state == ST_RD1) ? a1 : a0;
    reg_we    = 1'b0;
    reg_waddr = dphys;
    reg_wdata = reg_merge;
    reg_raddr = (state == ST_RD1) ? sphys : dphys;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = 8'h00;
        reg_we    = (clr_cnt < MEM_AW'(REG_COUNT));
        reg_waddr = clr_cnt[REG_AW-1:0];
        reg_wdata = (clr_cnt[REG_AW-1:0] == SP_INDEX) ? SP_RESET : 16'h0000;
      end
      ST_EX: begin
        mem_we = item.dest_is_memory;
        reg_we = !item.dest_is_memory;
      end
      ST_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = a1;
        mem_wdata = res[15:8];
      end
      default: begin
      end
    endcase
  end

  x86e_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_data_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  x86e_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_item;
      bad  <= in_item.dest_is_memory && (in_item.source_kind == SRC_MEM);
      res  <= 16'h0000;
    end
    if (state == ST_RD1) begin
      reg_d  <= reg_rdata;
      mem_lo <= mem_rdata;
    end
    if (state == ST_RD2) begin
      reg_s  <= reg_rdata;
      mem_hi <= mem_rdata;
    end
    if (state == ST_EX) begin
      res <= r;
    end
    if (state == ST_FIN && out_free) begin
      out_q <= '{bad_operands: bad, borrow_flag: borrow, result: res};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      borrow        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_EX && borrow_set) begin
        borrow <= 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + MEM_AW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (in_item.dest_is_memory && (in_item.source_kind == SRC_MEM)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_RD0;
            end
          end
        end
        ST_RD0:  state <= ST_RD1;
        ST_RD1:  state <= ST_RD2;
        ST_RD2:  state <= ST_EX;
        ST_EX: begin
          state <= (item.dest_is_memory && item.word_size) ? ST_WR1 : ST_FIN;
        end
        ST_WR1:  state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `X86E_ASSERT_NXT(a_borrow_sticky, clk, rst, borrow, borrow)
  `X86E_ASSERT_IMP(a_mem_write_dest, clk, rst, mem_we && (state != ST_CLEAR), item.dest_is_memory && !bad)
  `X86E_ASSERT_IMP(a_bad_zero_result, clk, rst, m_axis_tvalid && out_q.bad_operands, out_q.result == 16'h0000)
  `X86E_ASSERT_NXT(a_bad_skips_rmw, clk, rst, in_fire && in_item.dest_is_memory && (in_item.source_kind == SRC_MEM), state == ST_FIN)

endmodule

`default_nettype wire

FILE: tb/x86e_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the x86 ALU executor: watches both stream channels, predicts each result
// from its own register file, byte memory and borrow flag, and compares field by field.
// Depends on x86e_pkg.

module x86e_checker
  import x86e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          checked
);

  logic [15:0] gpr [REG_COUNT];
  logic [7:0]  data_mem [MEM_BYTES];
  logic        borrow_sticky;
  res_t        alu_results_q [$];
  int          err_count = 0;
  int          cmp_count = 0;
  int          wait_count = 0;

  assign errors  = err_count;
  assign pending = wait_count;
  assign checked = cmp_count;

  task report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    err_count++;
  endtask

  function logic [15:0] gpr_read(input logic [2:0] idx, input logic word);
    if (word) begin
      return gpr[idx];
    end
    return idx[0] ? {8'h00, gpr[{1'b0, idx[2:1]}][15:8]} : {8'h00, gpr[{1'b0, idx[2:1]}][7:0]};
  endfunction

  function logic [15:0] mem_read(input logic [15:0] a, input logic word);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {word ? data_mem[a1] : 8'h00, data_mem[a]};
  endfunction

  function res_t alu_execute(input item_t it);
    res_t        r;
    logic [15:0] mask;
    logic [15:0] d;
    logic [15:0] s;
    logic [15:0] v;
    logic [15:0] a1;
    r = '0;
    v = '0;
    if (it.dest_is_memory && it.source_kind == SRC_MEM) begin
      r.borrow_flag  = borrow_sticky;
      r.bad_operands = 1'b1;
      return r;
    end
    mask = it.word_size ? 16'hFFFF : 16'h00FF;
    d = it.dest_is_memory ? mem_read(it.address, it.word_size)
                          : gpr_read(it.dest_reg, it.word_size);
    if (it.source_kind == SRC_REG) begin
      s = gpr_read(it.src_reg, it.word_size);
    end else if (it.source_kind == SRC_MEM) begin
      s = mem_read(it.address, it.word_size);
    end else begin
      s = it.immediate & mask;
    end
    case (op_t'(it.mode))
      OP_MOV: v = s;
      OP_ADD: v = (d + s) & mask;
      OP_AND: v = d & s;
      OP_OR:  v = d | s;
      OP_XOR: v = d ^ s;
      OP_SUB: begin
        if (d < s) borrow_sticky = 1'b1;
        v = (d - s) & mask;
      end
      OP_INC: v = (d + 16'd1) & mask;
      OP_DEC: begin
        if (d == 16'd0) borrow_sticky = 1'b1;
        v = (d - 16'd1) & mask;
      end
    endcase
    if (it.dest_is_memory) begin
      a1 = it.address + 16'd1;
      data_mem[it.address] = v[7:0];
      if (it.word_size) data_mem[a1] = v[15:8];
    end else if (it.word_size) begin
      gpr[it.dest_reg] = v;
    end else if (it.dest_reg[0]) begin
      gpr[{1'b0, it.dest_reg[2:1]}][15:8] = v[7:0];
    end else begin
      gpr[{1'b0, it.dest_reg[2:1]}][7:0] = v[7:0];
    end
    r.result      = v;
    r.borrow_flag = borrow_sticky;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      gpr[SP_INDEX] = SP_RESET;
      for (int i = 0; i < MEM_BYTES; i++) data_mem[i] = '0;
      borrow_sticky = 1'b0;
      alu_results_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[17:0]);
        if (alu_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", got, 0);
        end else begin
          want = alu_results_q.pop_front();
          cmp_count++;
          if (got.result !== want.result)
            report_mismatch("result", got.result, want.result);
          if (got.borrow_flag !== want.borrow_flag)
            report_mismatch("borrow_flag", got.borrow_flag, want.borrow_flag);
          if (got.bad_operands !== want.bad_operands)
            report_mismatch("bad_operands", got.bad_operands, want.bad_operands);
        end
      end
      if (s_tvalid && s_tready) begin
        alu_results_q.push_back(alu_execute(item_t'(s_tdata[44:0])));
      end
    end
    wait_count = alu_results_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Top of the x86 ALU executor testbench: clock, reset, directed and random transactions,
// output stalls, watchdog and verdict. Depends on x86e_pkg, x86e_checker and the executor.

module tb;
  import x86e_pkg::*;

  localparam logic [1:0] SRC_IMM   = 2'd2;
  localparam logic [1:0] SRC_SPARE = 2'd3;

  localparam logic [2:0] R_AX = 3'd0, R_BX = 3'd1, R_CX = 3'd2, R_DX = 3'd3;
  localparam logic [2:0] R_DI = 3'd4, R_SI = 3'd5, R_BP = 3'd6;
  localparam logic [2:0] R_AL = 3'd0, R_AH = 3'd1, R_BL = 3'd2, R_BH = 3'd3;
  localparam logic [2:0] R_CL = 3'd4, R_CH = 3'd5, R_DL = 3'd6, R_DH = 3'd7;

  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int errors;
  int pending;
  int checked;
  int burst_left = 0;
  int sent = 0;
  int bad_sent = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  x86_alu_register_memory_executor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  x86e_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t mk(input op_t op, input logic w, input logic dm,
                               input logic [1:0] sk, input logic [2:0] dr,
                               input logic [2:0] sr, input logic [15:0] a,
                               input logic [15:0] imm);
    item_t it;
    it.mode           = op;
    it.word_size      = w;
    it.dest_is_memory = dm;
    it.source_kind    = sk;
    it.dest_reg       = dr;
    it.src_reg        = sr;
    it.address        = a;
    it.immediate      = imm;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it.mode      = 3'($urandom_range(0, 7));
    it.word_size = 1'($urandom_range(0, 1));
    it.dest_reg  = 3'($urandom_range(0, 7));
    it.src_reg   = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.dest_is_memory = 1'b1;
      it.source_kind    = SRC_MEM;
    end else begin
      it.dest_is_memory = 1'($urandom_range(0, 1));
      it.source_kind    = (pick < 14) ? SRC_SPARE : 2'($urandom_range(0, 2));
      if (it.dest_is_memory && it.source_kind == SRC_MEM) it.source_kind = SRC_IMM;
    end
    // keep most traffic on a few addresses so memory values get reused
    case ($urandom_range(0, 11))
      0:       it.address = 16'h0000;
      1:       it.address = 16'h0001;
      2:       it.address = 16'h0002;
      3:       it.address = 16'h7FFF;
      4:       it.address = 16'h8000;
      5:       it.address = 16'h8001;
      6:       it.address = 16'hFFFE;
      7:       it.address = 16'hFFFF;
      8:       it.address = 16'h0100;
      default: it.address = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       it.immediate = 16'h0000;
      1:       it.immediate = 16'hFFFF;
      2:       it.immediate = 16'h0001;
      3:       it.immediate = 16'h00FF;
      default: it.immediate = 16'($urandom_range(0, 65535));
    endcase
    return it;
  endfunction

  task send(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 15);
        @(negedge clk) s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    sent++;
    if (it.dest_is_memory && it.source_kind == SRC_MEM) bad_sent++;
  endtask

  task drain();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin : output_stall
    int len;
    int style;
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk) m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(10, 200);
        repeat (len) begin
          @(negedge clk);
          case (style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end while (idle < STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send(mk(OP_MOV, 1'b1, 1'b0, SRC_IMM,   R_AX, R_AX, 16'h0000, 16'hFFFF));
    send(mk(OP_MOV, 1'b0, 1'b0, SRC_IMM,   R_AH, R_AL, 16'h0000, 16'h12A5));
    send(mk(OP_ADD, 1'b1, 1'b0, SRC_IMM,   R_AX, R_AX, 16'h0000, 16'h0001));
    send(mk(OP_MOV, 1'b1, 1'b1, SRC_REG,   R_AX, R_AX, 16'hFFFF, 16'h0000));
    send(mk(OP_MOV, 1'b1, 1'b0, SRC_MEM,   R_BX, R_AX, 16'hFFFF, 16'h0000));
    send(mk(OP_AND, 1'b0, 1'b0, SRC_REG,   R_DL, R_BL, 16'h0000, 16'h0000));
    send(mk(OP_OR,  1'b1, 1'b1, SRC_IMM,   R_AX, R_AX, 16'h0000, 16'h8001));
    send(mk(OP_XOR, 1'b0, 1'b1, SRC_REG,   R_AX, R_AH, 16'h0001, 16'h0000));
    send(mk(OP_INC, 1'b1, 1'b0, SRC_REG,   SP_INDEX, R_AX, 16'h0000, 16'h0000));
    send(mk(OP_INC, 1'b1, 1'b0, SRC_IMM,   SP_INDEX, R_AX, 16'h0000, 16'hFFFF));
    send(mk(OP_INC, 1'b0, 1'b1, SRC_REG,   R_AX, R_AX, 16'hFFFF, 16'h0000));
    send(mk(OP_ADD, 1'b0, 1'b0, SRC_IMM,   R_AL, R_AL, 16'h0000, 16'hFFFF));
    send(mk(OP_SUB, 1'b1, 1'b0, SRC_IMM,   R_CX, R_AX, 16'h0000, 16'h0000));
    send(mk(OP_MOV, 1'b1, 1'b1, SRC_MEM,   R_AX, R_AX, 16'h0000, 16'hFFFF));
    send(mk(OP_INC, 1'b0, 1'b1, SRC_MEM,   R_AX, R_AX, 16'hFFFF, 16'h0000));
    send(mk(OP_ADD, 1'b1, 1'b0, SRC_SPARE, R_SI, R_DI, 16'h0000, 16'hFFFF));
    send(mk(OP_MOV, 1'b1, 1'b0, SRC_REG,   R_BP, SP_INDEX, 16'h0000, 16'h0000));
    send(mk(OP_MOV, 1'b0, 1'b0, SRC_MEM,   R_CH, R_DH, 16'h0001, 16'h0000));
    send(mk(OP_SUB, 1'b0, 1'b0, SRC_IMM,   R_BH, R_AL, 16'h0000, 16'h0001));
    send(mk(OP_DEC, 1'b1, 1'b1, SRC_IMM,   R_AX, R_AX, 16'h8000, 16'h0000));
    send(mk(OP_DEC, 1'b0, 1'b0, SRC_REG,   R_CL, R_AX, 16'h0000, 16'h0000));
    send(mk(OP_SUB, 1'b1, 1'b1, SRC_REG,   R_AX, R_DX, 16'hFFFE, 16'h0000));
    send(mk(OP_SUB, 1'b1, 1'b1, SRC_MEM,   R_AX, R_AX, 16'h8000, 16'h0000));
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == 800) drain();
      send(rand_item());
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, %0d with both operands in memory; %0d results compared.",
             sent, bad_sent, checked);
    $display("Covered all operations on bytes and words, a long output stall and full drains.");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
